@@ hw/rtl/rva_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rva_pkg
// shared widths, operation codes and pipeline types of the rv64im execute unit
// ----------------------------------------------------------------------------
package rva_pkg;

    localparam int XLEN      = 64;
    localparam int WLEN      = 32;
    localparam int DIV_STEPS = XLEN;
    // word delay from the select stage up to the end of the divider
    localparam int DLY       = DIV_STEPS - 2;

    localparam logic [1:0] COMP_ALU  = 2'd0;
    localparam logic [1:0] COMP_MUL  = 2'd1;
    localparam logic [1:0] COMP_PASS = 2'd2;

    localparam logic [2:0] ALU_ADD  = 3'd0;
    localparam logic [2:0] ALU_SLL  = 3'd1;
    localparam logic [2:0] ALU_SLT  = 3'd2;
    localparam logic [2:0] ALU_SLTU = 3'd3;
    localparam logic [2:0] ALU_XOR  = 3'd4;
    localparam logic [2:0] ALU_SR   = 3'd5;
    localparam logic [2:0] ALU_OR   = 3'd6;
    localparam logic [2:0] ALU_AND  = 3'd7;

    localparam logic [2:0] MUL_MUL    = 3'd0;
    localparam logic [2:0] MUL_MULH   = 3'd1;
    localparam logic [2:0] MUL_MULHSU = 3'd2;
    localparam logic [2:0] MUL_MULHU  = 3'd3;
    localparam logic [2:0] MUL_DIV    = 3'd4;
    localparam logic [2:0] MUL_DIVU   = 3'd5;
    localparam logic [2:0] MUL_REM    = 3'd6;
    localparam logic [2:0] MUL_REMU   = 3'd7;

    typedef logic [XLEN-1:0] xword_t;

    // control that travels alongside the data words
    typedef struct packed {
        logic       use_div;
        logic       use_rem;
        logic       need_sext;
        logic       neg_q;
        logic       neg_r;
        logic       div_zero;
    } side_t;

    function automatic xword_t sext32(input xword_t x);
        return {{(XLEN-WLEN){x[WLEN-1]}}, x[WLEN-1:0]};
    endfunction

endpackage

@@ hw/rtl/rva_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rva_alu
// base integer operations, one registered stage
// ----------------------------------------------------------------------------
module rva_alu (
    input  logic             clk,
    input  logic [2:0]       op,
    input  logic             modified,
    input  logic             word_mode,
    input  rva_pkg::xword_t  a,
    input  rva_pkg::xword_t  b,
    output rva_pkg::xword_t  res_reg
);
    import rva_pkg::*;

    logic [5:0] sh;
    xword_t     res_next;

    always_comb
    begin
        sh = word_mode ? {1'b0, b[4:0]} : b[5:0];
        case (op)
            ALU_ADD:  res_next = modified ? a - b : a + b;
            ALU_SLL:  res_next = a << sh;
            ALU_SLT:  res_next = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
            ALU_SLTU: res_next = {{(XLEN-1){1'b0}}, a < b};
            ALU_XOR:  res_next = a ^ b;
            ALU_SR:   res_next = modified ? xword_t'($signed(a) >>> sh) : a >> sh;
            ALU_OR:   res_next = a | b;
            ALU_AND:  res_next = (modified ? ~a : a) & b;
            default:  res_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

@@ hw/rtl/rva_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rva_mul
// 64x64 multiplier from four 32x32 partial products, two register stages
// ----------------------------------------------------------------------------
module rva_mul (
    input  logic             clk,
    input  logic [2:0]       op,
    input  logic             word_mode,
    input  rva_pkg::xword_t  a,
    input  rva_pkg::xword_t  b,
    output rva_pkg::xword_t  res
);
    import rva_pkg::*;

    xword_t               ll_reg, lh_reg, hl_reg, hh_reg, corr_reg;
    logic [2:0]           op2_reg, op3_reg;
    logic                 word2_reg, word3_reg;
    logic [2*XLEN-1:0]    prod_reg;
    xword_t               corr3_reg;
    xword_t               corr_next;
    logic [2*XLEN-1:0]    prod_next;
    xword_t               hi;

    // signed high products: subtract the cross terms of negative operands
    always_comb
    begin
        corr_next = ((a[XLEN-1] && (op == MUL_MULH || op == MUL_MULHSU)) ? b : '0)
                  + ((b[XLEN-1] && op == MUL_MULH) ? a : '0);
    end

    always_ff @(posedge clk)
    begin
        ll_reg    <= XLEN'(a[WLEN-1:0] * b[WLEN-1:0]);
        lh_reg    <= XLEN'(a[WLEN-1:0] * b[XLEN-1:WLEN]);
        hl_reg    <= XLEN'(a[XLEN-1:WLEN] * b[WLEN-1:0]);
        hh_reg    <= XLEN'(a[XLEN-1:WLEN] * b[XLEN-1:WLEN]);
        corr_reg  <= corr_next;
        op2_reg   <= op;
        word2_reg <= word_mode;
    end

    always_comb
    begin
        prod_next = {hh_reg, ll_reg}
                  + {{WLEN{1'b0}}, lh_reg, {WLEN{1'b0}}}
                  + {{WLEN{1'b0}}, hl_reg, {WLEN{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        corr3_reg <= corr_reg;
        op3_reg   <= op2_reg;
        word3_reg <= word2_reg;
    end

    always_comb
    begin
        hi = prod_reg[2*XLEN-1:XLEN] - corr3_reg;
        if (op3_reg == MUL_MUL)
            res = prod_reg[XLEN-1:0];
        else if (word3_reg)
            res = {{(XLEN-WLEN){1'b0}}, prod_reg[XLEN-1:WLEN]};
        else
            res = hi;
    end

endmodule

@@ hw/rtl/rva_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rva_div
// unsigned restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
module rva_div (
    input  logic             clk,
    input  rva_pkg::xword_t  dividend,
    input  rva_pkg::xword_t  divisor,
    output rva_pkg::xword_t  quo,
    output rva_pkg::xword_t  rem
);
    import rva_pkg::*;

    xword_t rem_reg [DIV_STEPS];
    xword_t quo_reg [DIV_STEPS];
    xword_t dvs_reg [DIV_STEPS];
    xword_t rem_next [DIV_STEPS];
    xword_t quo_next [DIV_STEPS];
    xword_t dvs_next [DIV_STEPS];

    always_comb
    begin
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            logic [XLEN:0] t;
            logic [XLEN:0] diff;
            xword_t        r_in, q_in, d_in;
            r_in = (i == 0) ? '0 : rem_reg[i-1];
            q_in = (i == 0) ? dividend : quo_reg[i-1];
            d_in = (i == 0) ? divisor : dvs_reg[i-1];
            t    = {r_in, q_in[XLEN-1]};
            diff = t - {1'b0, d_in};
            rem_next[i] = diff[XLEN] ? t[XLEN-1:0] : diff[XLEN-1:0];
            quo_next[i] = {q_in[XLEN-2:0], ~diff[XLEN]};
            dvs_next[i] = d_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            rem_reg[i] <= rem_next[i];
            quo_reg[i] <= quo_next[i];
            dvs_reg[i] <= dvs_next[i];
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];
    assign rem = rem_reg[DIV_STEPS-1];

endmodule

@@ hw/rtl/rv64im_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64im_alu
// pipelined rv64im execute unit: base alu, multiply, divide and pass-through
// ----------------------------------------------------------------------------
//  channel   handshake            word
//  command   start, busy          op, component, word_mode, modified,
//                                 operand_a, operand_b
//  result    done (one cycle)     result
//
//  one word enters per cycle; busy is always low
//  every word passes the input and operand prep stages, the 64 divider stages
//  (or the delay line that matches them) and the final sign-fix stage
//  all words share one fixed-latency path, so order is kept
//  reset clears only the valid bits; the result side cannot stall
// ----------------------------------------------------------------------------
module rv64im_alu (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       op,
    input  logic [1:0]       component,
    input  logic             word_mode,
    input  logic             modified,
    input  rva_pkg::xword_t  operand_a,
    input  rva_pkg::xword_t  operand_b,
    output logic             done,
    output rva_pkg::xword_t  result
);
    import rva_pkg::*;

    // input stage
    logic       v0_reg;
    logic [2:0] op0_reg;
    logic [1:0] comp0_reg;
    logic       word0_reg, mod0_reg;
    xword_t     a0_reg, b0_reg;

    // operand prep stage
    logic       v1_reg;
    logic [2:0] op1_reg;
    logic [1:0] comp1_reg;
    logic       word1_reg, mod1_reg;
    xword_t     a1_reg, wa1_reg, wb1_reg, ma1_reg, mb1_reg;
    side_t      side1_reg;

    // stages two and three
    logic       v2_reg, v3_reg;
    logic [1:0] comp2_reg, comp3_reg;
    xword_t     a2_reg, a3_reg, alu3_reg;
    side_t      side2_reg, side3_reg;

    // delay line up to the divider output
    logic       dv_reg   [DLY];
    side_t      dside_reg [DLY];
    xword_t     dword_reg [DLY];

    logic       done_reg;
    xword_t     result_reg;

    logic       sgn_a, sgn_b, div_signed;
    xword_t     wa_next, wb_next;
    side_t      side_next;
    xword_t     alu_res, mul_res, early_next;
    xword_t     quo, rem, q_fix, r_fix, val, result_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        op0_reg   <= op;
        comp0_reg <= component;
        word0_reg <= word_mode;
        mod0_reg  <= modified;
        a0_reg    <= operand_a;
        b0_reg    <= operand_b;
    end

    // word mode: signed operations see sign-extended operands
    always_comb
    begin
        if (comp0_reg == COMP_ALU)
        begin
            sgn_a = (op0_reg == ALU_SLT) || (op0_reg == ALU_SR && mod0_reg);
            sgn_b = (op0_reg == ALU_SLT);
        end
        else
        begin
            sgn_a = op0_reg inside {MUL_MULH, MUL_MULHSU, MUL_DIV, MUL_REM};
            sgn_b = op0_reg inside {MUL_MULH, MUL_DIV, MUL_REM};
        end
        if (word0_reg)
        begin
            wa_next = sgn_a ? sext32(a0_reg) : {{(XLEN-WLEN){1'b0}}, a0_reg[WLEN-1:0]};
            wb_next = sgn_b ? sext32(b0_reg) : {{(XLEN-WLEN){1'b0}}, b0_reg[WLEN-1:0]};
        end
        else
        begin
            wa_next = a0_reg;
            wb_next = b0_reg;
        end
        div_signed = op0_reg == MUL_DIV || op0_reg == MUL_REM;
        side_next.use_div   = comp0_reg == COMP_MUL && op0_reg[2];
        side_next.use_rem   = op0_reg[1];
        side_next.need_sext = word0_reg
                            && (comp0_reg == COMP_ALU || comp0_reg == COMP_MUL);
        side_next.neg_q     = div_signed && (wa_next[XLEN-1] ^ wb_next[XLEN-1]);
        side_next.neg_r     = div_signed && wa_next[XLEN-1];
        side_next.div_zero  = wb_next == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg   <= op0_reg;
        comp1_reg <= comp0_reg;
        word1_reg <= word0_reg;
        mod1_reg  <= mod0_reg;
        a1_reg    <= a0_reg;
        wa1_reg   <= wa_next;
        wb1_reg   <= wb_next;
        // divider works on magnitudes
        ma1_reg   <= (div_signed && wa_next[XLEN-1]) ? '0 - wa_next : wa_next;
        mb1_reg   <= (div_signed && wb_next[XLEN-1]) ? '0 - wb_next : wb_next;
        side1_reg <= side_next;

        comp2_reg <= comp1_reg;
        a2_reg    <= a1_reg;
        side2_reg <= side1_reg;

        comp3_reg <= comp2_reg;
        a3_reg    <= a2_reg;
        alu3_reg  <= alu_res;
        side3_reg <= side2_reg;
    end

    rva_alu u_alu (
        .clk       (clk),
        .op        (op1_reg),
        .modified  (mod1_reg),
        .word_mode (word1_reg),
        .a         (wa1_reg),
        .b         (wb1_reg),
        .res_reg   (alu_res)
    );

    rva_mul u_mul (
        .clk       (clk),
        .op        (op1_reg),
        .word_mode (word1_reg),
        .a         (wa1_reg),
        .b         (wb1_reg),
        .res       (mul_res)
    );

    rva_div u_div (
        .clk      (clk),
        .dividend (ma1_reg),
        .divisor  (mb1_reg),
        .quo      (quo),
        .rem      (rem)
    );

    // pick the non-divide word; unused component code gives zero
    always_comb
    begin
        case (comp3_reg)
            COMP_ALU:  early_next = alu3_reg;
            COMP_MUL:  early_next = mul_res;
            COMP_PASS: early_next = a3_reg;
            default:   early_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DLY; i++)
                dv_reg[i] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= v3_reg;
            for (int i = 1; i < DLY; i++)
                dv_reg[i] <= dv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dside_reg[0] <= side3_reg;
        dword_reg[0] <= early_next;
        for (int i = 1; i < DLY; i++)
        begin
            dside_reg[i] <= dside_reg[i-1];
            dword_reg[i] <= dword_reg[i-1];
        end
    end

    // sign fix of the divider, final select and word-mode extension
    always_comb
    begin
        q_fix = dside_reg[DLY-1].div_zero ? '1
              : (dside_reg[DLY-1].neg_q ? '0 - quo : quo);
        r_fix = dside_reg[DLY-1].neg_r ? '0 - rem : rem;
        if (dside_reg[DLY-1].use_div)
            val = dside_reg[DLY-1].use_rem ? r_fix : q_fix;
        else
            val = dword_reg[DLY-1];
        result_next = dside_reg[DLY-1].need_sext ? sext32(val) : val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_reg[DLY-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rv64im execute unit: directed corner words for
// every component and base alu op, then random words with random start
// gaps; each done word is compared against a behavioral model of the unit
// ----------------------------------------------------------------------------
module tb;
    import rva_pkg::*;

    localparam logic [1:0] COMP_NONE  = 2'd3;
    localparam longint     CYCLE_CAP  = 400000;
    localparam int         DRAIN_WAIT = 80;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  op;
    logic [1:0]  component;
    logic        word_mode;
    logic        modified;
    xword_t      operand_a;
    xword_t      operand_b;
    logic        done;
    xword_t      result;

    // expected results in issue order
    xword_t      expected_results[$];
    int          mismatches;
    longint      cycle_count;
    bit          gaps_on;

    rv64im_alu u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .component (component),
        .word_mode (word_mode),
        .modified  (modified),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .done      (done),
        .result    (result)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // behavioral model
    // ------------------------------------------------------------------
    function automatic xword_t sx32(input xword_t x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

    function automatic xword_t base_alu_value(input logic [2:0] code, input logic md,
                                              input xword_t a, input xword_t b,
                                              input logic wd);
        logic [5:0] sh;
        sh = wd ? {1'b0, b[4:0]} : b[5:0];
        case (code)
            ALU_ADD:  return md ? a - b : a + b;
            ALU_SLL:  return a << sh;
            ALU_SLT:  return ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
            ALU_SLTU: return (a < b) ? 64'd1 : 64'd0;
            ALU_XOR:  return a ^ b;
            ALU_SR:   return md ? xword_t'($signed(a) >>> sh) : a >> sh;
            ALU_OR:   return a | b;
            default:  return (md ? ~a : a) & b;
        endcase
    endfunction

    function automatic xword_t muldiv_value(input logic [2:0] code,
                                            input xword_t a, input xword_t b);
        logic signed [129:0] prod;
        xword_t              ma;
        xword_t              mb;
        case (code)
            MUL_MUL:    return a * b;
            MUL_MULH:
            begin
                prod = $signed({{66{a[63]}}, a}) * $signed({{66{b[63]}}, b});
                return prod[127:64];
            end
            MUL_MULHSU:
            begin
                prod = $signed({{66{a[63]}}, a}) * $signed({66'd0, b});
                return prod[127:64];
            end
            MUL_MULHU:
            begin
                prod = $signed({66'd0, a}) * $signed({66'd0, b});
                return prod[127:64];
            end
            MUL_DIV, MUL_REM:
            begin
                if (b == 0)
                    return (code == MUL_DIV) ? '1 : a;
                if (a == 64'h8000_0000_0000_0000 && b == '1)
                    return (code == MUL_DIV) ? a : '0;
                ma = a[63] ? -a : a;
                mb = b[63] ? -b : b;
                if (code == MUL_DIV)
                    return (a[63] != b[63]) ? -(ma / mb) : ma / mb;
                return a[63] ? -(ma % mb) : ma % mb;
            end
            MUL_DIVU:   return (b == 0) ? '1 : a / b;
            default:    return (b == 0) ? a : a % b;
        endcase
    endfunction

    function automatic xword_t execute_value(input logic [2:0] code, input logic [1:0] comp,
                                             input logic wd, input logic md,
                                             input xword_t a, input xword_t b);
        logic   sa;
        logic   sb;
        xword_t wa;
        xword_t wb;
        xword_t r;
        if (comp == COMP_PASS)
            return a;
        if (comp == COMP_NONE)
            return '0;
        if (!wd)
            return (comp == COMP_ALU) ? base_alu_value(code, md, a, b, 1'b0)
                                      : muldiv_value(code, a, b);
        // word mode: signed ops see sign-extended operands, others zero-extended
        if (comp == COMP_ALU)
        begin
            sa = (code == ALU_SLT) || (code == ALU_SR && md);
            sb = (code == ALU_SLT);
        end
        else
        begin
            sa = code inside {MUL_MULH, MUL_MULHSU, MUL_DIV, MUL_REM};
            sb = code inside {MUL_MULH, MUL_DIV, MUL_REM};
        end
        wa = sa ? sx32(a) : {32'd0, a[31:0]};
        wb = sb ? sx32(b) : {32'd0, b[31:0]};
        if (comp == COMP_ALU)
            r = base_alu_value(code, md, wa, wb, 1'b1);
        else if (code inside {MUL_MULH, MUL_MULHSU, MUL_MULHU})
            r = (wa * wb) >> 32;
        else
            r = muldiv_value(code, wa, wb);
        return sx32(r);
    endfunction

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------
    task automatic send_word(input logic [2:0] code, input logic [1:0] comp,
                             input logic wd, input logic md,
                             input xword_t a, input xword_t b);
        int gap;
        // random start gaps in bursts
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        op        <= code;
        component <= comp;
        word_mode <= wd;
        modified  <= md;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(execute_value(code, comp, wd, md, a, b));
    endtask

    task automatic idle_start();
        start <= 1'b0;
    endtask

    function automatic xword_t rand_xword();
        xword_t v;
        v = {$urandom, $urandom};
        // bias toward interesting patterns
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = 64'h8000_0000_0000_0000;
            3: v = sx32({32'd0, $urandom});
            4: v = 64'($urandom_range(0, 70));
            default: ;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_base_alu_corners();
        xword_t vals[4];
        vals = '{64'd0, '1, 64'h8000_0000_0000_0000, 64'h0000_0000_8000_003f};
        for (int c = 0; c < 8; c++)
            for (int m = 0; m < 2; m++)
                send_word(c[2:0], COMP_ALU, m[0], m[0], vals[c % 4], vals[(c + 1) % 4]);
    endtask

    task automatic test_muldiv_corners();
        // divide by zero, signed overflow, high products and word-mode variants
        send_word(MUL_DIV,  COMP_MUL, 1'b0, 1'b0, 64'd7, 64'd0);
        send_word(MUL_REMU, COMP_MUL, 1'b0, 1'b1, 64'd7, 64'd0);
        send_word(MUL_DIV,  COMP_MUL, 1'b0, 1'b0, 64'h8000_0000_0000_0000, '1);
        send_word(MUL_REM,  COMP_MUL, 1'b0, 1'b0, 64'h8000_0000_0000_0000, '1);
        send_word(MUL_DIV,  COMP_MUL, 1'b1, 1'b0, 64'h8000_0000, 64'hffff_ffff);
        send_word(MUL_MULH, COMP_MUL, 1'b0, 1'b0, '1, 64'h8000_0000_0000_0000);
        send_word(MUL_MULHSU, COMP_MUL, 1'b1, 1'b0, 64'hffff_ffff, 64'hffff_ffff);
        send_word(MUL_MULHU, COMP_MUL, 1'b1, 1'b0, '1, '1);
        // pass-through ignores word mode; unused component gives zero
        send_word(ALU_ADD, COMP_PASS, 1'b1, 1'b1, '1, 64'd5);
        send_word(ALU_OR,  COMP_NONE, 1'b0, 1'b0, '1, '1);
    endtask

    task automatic test_random_words(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count - count / 5)
                gaps_on = 1'b0;
            send_word(3'($urandom_range(0, 7)),
                      ($urandom_range(0, 15) == 0) ? COMP_NONE : 2'($urandom_range(0, 2)),
                      1'($urandom), 1'($urandom), rand_xword(), rand_xword());
        end
    endtask

    // ------------------------------------------------------------------
    // result checker: done is a one-cycle strobe
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result: unexpected word, actual %h", result);
                mismatches++;
            end
            else if (result !== expected_results[0])
            begin
                $error("result: expected %h actual %h", expected_results[0], result);
                mismatches++;
                void'(expected_results.pop_front());
            end
            else
                void'(expected_results.pop_front());
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("rv64im_alu verification failed");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
        mismatches  = 0;
        gaps_on     = 1'b1;
        rst_n       = 1'b0;
        start       = 1'b0;
        op          = '0;
        component   = '0;
        word_mode   = 1'b0;
        modified    = 1'b0;
        operand_a   = '0;
        operand_b   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_base_alu_corners();
        test_muldiv_corners();
        test_random_words(800);
        idle_start();

        // drain: wait for outstanding words, then wait out DRAIN_WAIT
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("rv64im_alu verification clean");
        else
            $display("rv64im_alu verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rva_pkg.sv
hw/rtl/rva_alu.sv
hw/rtl/rva_mul.sv
hw/rtl/rva_div.sv
hw/rtl/rv64im_alu.sv
tb/tb.sv
